### rtl/shad_pkg.sv
package shad_pkg;

   typedef logic [31:0] word_type;

   localparam logic [63:0][31:0] ROUND_K = {
      32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
      32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
      32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
      32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
      32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
      32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
      32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
      32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
      32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
      32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
      32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
      32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
      32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
      32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
      32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
      32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

   localparam logic [7:0][31:0] INIT_HASH = {
      32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
      32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // One entry of the queue between front and back.
   typedef struct packed {
      logic       finish;
      logic [7:0] data_byte;
   } cmd_type;

   function automatic word_type rotr(input word_type x, input int k);
      rotr = (x >> k) | (x << (32 - k));
   endfunction

endpackage

### rtl/shad_if.sv
interface shad_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   modport source (output valid, kind, data_byte, input ready);
   modport sink (input valid, kind, data_byte, output ready);
endinterface

interface shad_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/shad_front.sv
module shad_front
   import shad_pkg::*;
#(
   parameter int Depth = 4
) (
   input  logic    clock,
   input  logic    reset,
   shad_req_if.sink req,
   output cmd_type cmd,
   output logic    cmd_valid,
   input  logic    cmd_ready
);

   localparam int AW = $clog2(Depth);

   cmd_type         fifo_ff [Depth];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [AW:0]     cnt_ff;
   logic            push, pop;

   assign req.ready = (cnt_ff != (AW+1)'(Depth));
   assign push      = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = fifo_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            fifo_ff[wr_ff] <= '{finish: (req.kind == KIND_FINISH),
                                data_byte: req.data_byte};
            wr_ff <= (wr_ff == AW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) rd_ff <= (rd_ff == AW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(Depth)) else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");

endmodule

### rtl/shad_back.sv
module shad_back
   import shad_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  logic      cmd_valid,
   output logic      cmd_ready,
   shad_rsp_if.source rsp
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_RUN, ST_ADD, ST_EMIT
   } state_type;

   state_type        state_ff;
   logic [15:0][31:0] w_ff;         // schedule window, w_ff[0] is oldest
   logic [7:0][31:0]  h_ff;
   logic [7:0][31:0]  v_ff;         // a..h
   logic [60:0]       count_ff;
   logic [5:0]        round_ff;
   logic [5:0]        pad_ff;       // byte position while padding
   logic              finish_ff;    // compressing a padded block
   logic              second_ff;    // another padded block follows
   logic [63:0]       bits_ff;
   logic [2:0]        idx_ff;
   logic [23:0]       acc_ff;       // bytes of the word being gathered
   logic [7:0]        pad_byte;
   logic [31:0]       w_cur, w_new, t0, t1, s0, s1;
   logic [31:0]       m2, m15, e, a;

   assign cmd_ready = (state_ff == ST_IDLE);

   // Byte being shifted in on a padding step. Positions 56 to 63 of the
   // final block carry the bit length, most significant byte first.
   always_comb begin
      if (pad_ff >= 6'd56 && !second_ff) pad_byte = bits_ff[{~pad_ff[2:0], 3'b111} -: 8];
      else                               pad_byte = 8'h00;
   end

   assign m2  = w_ff[14];
   assign m15 = w_ff[1];
   assign s1  = rotr(m2, 17) ^ rotr(m2, 19) ^ (m2 >> 10);
   assign s0  = rotr(m15, 7) ^ rotr(m15, 18) ^ (m15 >> 3);
   assign w_new = s1 + w_ff[9] + s0 + w_ff[0];
   assign w_cur = (round_ff < 6'd16) ? w_ff[round_ff[3:0]] : w_new;
   assign a  = v_ff[0];
   assign e  = v_ff[4];
   assign t0 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
             + (v_ff[6] ^ (e & (v_ff[5] ^ v_ff[6]))) + ROUND_K[round_ff] + w_cur;
   assign t1 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
             + ((a & v_ff[1]) | (v_ff[2] & (a | v_ff[1])));

   assign rsp.valid       = (state_ff == ST_EMIT);
   assign rsp.digest_word = h_ff[idx_ff];
   assign rsp.word_index  = idx_ff;
   assign rsp.last_word   = (idx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         h_ff     <= INIT_HASH;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  if (!cmd.finish) begin
                     // Bytes gather into a word; a complete word enters the window.
                     acc_ff <= {acc_ff[15:0], cmd.data_byte};
                     if (count_ff[1:0] == 2'd3)
                        w_ff <= {{acc_ff, cmd.data_byte}, w_ff[15:1]};
                     count_ff <= count_ff + 1'b1;
                     finish_ff <= 1'b0;
                     if (count_ff[5:0] == 6'd63) begin
                        state_ff <= ST_RUN;
                        round_ff <= '0;
                        v_ff     <= h_ff;
                     end
                  end else begin
                     acc_ff <= {acc_ff[15:0], PAD_BYTE};
                     if (count_ff[1:0] == 2'd3)
                        w_ff <= {{acc_ff, PAD_BYTE}, w_ff[15:1]};
                     bits_ff  <= {count_ff, 3'b000};
                     pad_ff   <= count_ff[5:0] + 1'b1;
                     second_ff <= (count_ff[5:0] >= 6'd56);
                     finish_ff <= 1'b1;
                     state_ff <= (count_ff[5:0] == 6'd63) ? ST_RUN : ST_PAD;
                     round_ff <= '0;
                     v_ff     <= h_ff;
                  end
               end
            end
            ST_PAD: begin
               acc_ff <= {acc_ff[15:0], pad_byte};
               if (pad_ff[1:0] == 2'd3)
                  w_ff <= {{acc_ff, pad_byte}, w_ff[15:1]};
               pad_ff   <= pad_ff + 1'b1;
               if (pad_ff == 6'd63) begin
                  state_ff <= ST_RUN;
                  round_ff <= '0;
                  v_ff     <= h_ff;
               end
            end
            ST_RUN: begin
               if (round_ff >= 6'd16) w_ff <= {w_new, w_ff[15:1]};
               v_ff <= {v_ff[6:4], v_ff[3] + t0, v_ff[2:0], t0 + t1};
               round_ff <= round_ff + 1'b1;
               if (round_ff == 6'd63) state_ff <= ST_ADD;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               if (!finish_ff) state_ff <= ST_IDLE;
               else if (second_ff) begin
                  second_ff <= 1'b0;
                  pad_ff    <= '0;
                  state_ff  <= ST_PAD;
               end else begin
                  idx_ff   <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp.ready) begin
                  idx_ff <= idx_ff + 1'b1;
                  if (idx_ff == 3'd7) begin
                     h_ff     <= INIT_HASH;
                     count_ff <= '0;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.last_word |=> state_ff == ST_IDLE)
      else $error("digest did not end");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN && round_ff == 6'd63 |=> state_ff == ST_ADD)
      else $error("round count slip");
   assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> !rsp.valid) else $error("overlap");

endmodule

### rtl/sha256_message_digest_unit.sv
// SHA-256 digest unit.
// The req channel carries one item per message byte (kind 0) or a finish
// item (kind 1). The rsp channel returns the digest after a finish as eight
// 32-bit words, word_index 0 first, last_word set on the eighth.
// A four-entry queue decouples the request side from the hash engine, so
// requests are taken while the engine compresses or waits on rsp.
// Each data byte is gathered into the message window; every 64th byte
// starts the 64 rounds of the compression loop and the final chaining add. A
// finish pads the block one byte per cycle, compresses one or two blocks
// and then presents the words, one per cycle while rsp is ready.
// The engine takes no byte while it compresses, as the single shared round
// unit serves every round; the queue holds the bytes meanwhile.
// When rsp stalls, the current word holds and the engine waits; the queue
// keeps taking requests until it is full.
// A synchronous reset loads the initial hash values, clears the length and
// empties the queue. After each digest the engine returns to that state.
module sha256_message_digest_unit
   import shad_pkg::*;
#(
   parameter int QueueDepth = 4
) (
   input  logic        clock,
   input  logic        reset,
   shad_req_if.sink    req,
   shad_rsp_if.source  rsp
);

   cmd_type cmd;
   logic    cmd_valid, cmd_ready;

   shad_front #(.Depth(QueueDepth)) u_front (
      .clock, .reset, .req, .cmd, .cmd_valid, .cmd_ready);

   shad_back u_back (
      .clock, .reset, .cmd, .cmd_valid, .cmd_ready, .rsp);

endmodule

### sim/tb_sha256_message_digest_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the SHA-256 digest unit. Message bytes and finish
// items are streamed into the req channel, a behavioral hash engine predicts
// the eight digest words of every finish, and the rsp monitor compares each
// returned item against the oldest predicted word.
module tb_sha256_message_digest_unit;
   import shad_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int LongHold = 400;

   typedef struct {
      logic       kind;
      logic [7:0] data_byte;
   } req_item_t;

   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_item_t;

   // Round constants and initial hash of FIPS 180-4.
   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] SHA_H0 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   logic clock;
   logic reset;

   shad_req_if req_ch ();
   shad_rsp_if rsp_ch ();

   sha256_message_digest_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // Stimulus queue, predicted digest words and bookkeeping.
   req_item_t    stim_q[$];
   digest_item_t digest_q[$];
   int           total_items;
   int           sent_count;
   int           error_count;
   int           cycle_count;
   int           phase;
   bit           req_taken;
   bit           hold_done;
   int           hold_left;

   // Behavioral copy of the hash engine state.
   logic [31:0] chain_words [8];
   logic [7:0]  msg_block [64];
   logic [60:0] msg_bytes;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] rot_right(input logic [31:0] x, input int k);
      return (x >> k) | (x << (32 - k));
   endfunction

   // Compresses the 64-byte message block into the chaining words.
   task automatic compress_msg_block();
      logic [31:0] sched [16];
      logic [31:0] v [8];
      logic [31:0] w, s0, s1, t0, t1, x2, x15;
      int i;
      for (i = 0; i < 8; i++) v[i] = chain_words[i];
      for (i = 0; i < 64; i++) begin
         if (i < 16) begin
            w = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
         end else begin
            x2 = sched[(i - 2) & 15];
            x15 = sched[(i - 15) & 15];
            s1 = rot_right(x2, 17) ^ rot_right(x2, 19) ^ (x2 >> 10);
            s0 = rot_right(x15, 7) ^ rot_right(x15, 18) ^ (x15 >> 3);
            w = s1 + sched[(i - 7) & 15] + s0 + sched[i & 15];
         end
         sched[i & 15] = w;
         t0 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
              + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + SHA_K[i] + w;
         t1 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
              + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t0;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t0 + t1;
      end
      for (i = 0; i < 8; i++) chain_words[i] = chain_words[i] + v[i];
   endtask

   // Applies one accepted item to the engine copy; a finish pads the
   // message, queues the eight digest words and restarts the message.
   task automatic hash_accept(input req_item_t it);
      int pos;
      int i;
      logic [63:0] bit_len;
      digest_item_t d;
      pos = int'(msg_bytes[5:0]);
      if (it.kind == KIND_DATA) begin
         msg_block[pos] = it.data_byte;
         msg_bytes = msg_bytes + 61'd1;
         if (msg_bytes[5:0] == 6'd0) compress_msg_block();
      end else begin
         msg_block[pos] = 8'h80;
         pos++;
         // Fewer than eight bytes left for the length: spill into a second block.
         if (pos > 56) begin
            for (i = pos; i < 64; i++) msg_block[i] = 8'h00;
            compress_msg_block();
            pos = 0;
         end
         for (i = pos; i < 56; i++) msg_block[i] = 8'h00;
         bit_len = {msg_bytes, 3'b000};
         for (i = 0; i < 8; i++) msg_block[56 + i] = bit_len[63 - 8*i -: 8];
         compress_msg_block();
         for (i = 0; i < 8; i++) begin
            d.digest_word = chain_words[i];
            d.word_index = 3'(i);
            d.last_word = (i == 7);
            digest_q.push_back(d);
         end
         for (i = 0; i < 8; i++) chain_words[i] = SHA_H0[i];
         msg_bytes = '0;
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   task automatic add_message(input int len);
      req_item_t it;
      int i;
      for (i = 0; i < len; i++) begin
         it.kind = KIND_DATA;
         it.data_byte = 8'($urandom);
         stim_q.push_back(it);
      end
      // The byte field of a finish is ignored, so it carries noise.
      it.kind = KIND_FINISH;
      it.data_byte = 8'($urandom);
      stim_q.push_back(it);
   endtask

   task automatic add_byte(input logic [7:0] b);
      req_item_t it;
      it.kind = KIND_DATA;
      it.data_byte = b;
      stim_q.push_back(it);
   endtask

   task automatic add_finish();
      req_item_t it;
      it.kind = KIND_FINISH;
      it.data_byte = 8'h00;
      stim_q.push_back(it);
   endtask

   // Sample side: predictor update on every accepted request and the
   // digest checker on every accepted response, both at the rising edge.
   always @(posedge clock) begin
      digest_item_t exp_word;
      req_item_t    got_req;
      if (reset) begin
         for (int i = 0; i < 8; i++) chain_words[i] = SHA_H0[i];
         for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
         msg_bytes = '0;
      end else begin
         cycle_count++;
         if (req_ch.valid && req_ch.ready) begin
            got_req.kind = req_ch.kind;
            got_req.data_byte = req_ch.data_byte;
            hash_accept(got_req);
            req_taken = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (digest_q.size() == 0) begin
               report_mismatch($sformatf("digest word %h with nothing pending",
                                         rsp_ch.digest_word));
            end else begin
               exp_word = digest_q.pop_front();
               if (rsp_ch.digest_word !== exp_word.digest_word)
                  report_mismatch($sformatf("digest_word %h, expected %h",
                                            rsp_ch.digest_word, exp_word.digest_word));
               if (rsp_ch.word_index !== exp_word.word_index)
                  report_mismatch($sformatf("word_index %0d, expected %0d",
                                            rsp_ch.word_index, exp_word.word_index));
               if (rsp_ch.last_word !== exp_word.last_word)
                  report_mismatch($sformatf("last_word %b, expected %b",
                                            rsp_ch.last_word, exp_word.last_word));
            end
         end
         if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_sha256_message_digest_unit: errors");
            $finish;
         end
      end
   end

   // Request driver. A new item is presented only once the previous one was
   // taken. The phase follows how far the stimulus has progressed: no
   // idling, sender idle, receiver stall, then both.
   always @(negedge clock) begin
      req_item_t it;
      bit sender_idles;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.kind <= KIND_DATA;
         req_ch.data_byte <= 8'h00;
         req_taken = 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         req_taken = 1'b0;
         phase = (total_items > 0) ? (sent_count * 4) / total_items : 0;
         sender_idles = (phase == 1 && $urandom_range(99) < 57) ||
                        (phase == 3 && $urandom_range(99) < 31);
         if (stim_q.size() > 0 && !sender_idles) begin
            it = stim_q.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.kind <= it.kind;
            req_ch.data_byte <= it.data_byte;
            sent_count++;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response ready. At the start of the receiver-stall phase it holds off
   // for a long stretch so the internal queue fills and req backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && phase == 2) begin
         hold_done = 1'b1;
         hold_left = LongHold;
         rsp_ch.ready <= 1'b0;
      end else if (phase == 2) begin
         rsp_ch.ready <= ($urandom_range(99) >= 57);
      end else if (phase == 3) begin
         rsp_ch.ready <= ($urandom_range(99) >= 31);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   initial begin
      int len;
      int pick;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_DATA;
      req_ch.data_byte = 8'h00;
      rsp_ch.ready = 1'b0;
      error_count = 0;
      cycle_count = 0;
      sent_count = 0;
      total_items = 0;
      phase = 0;
      hold_done = 1'b0;
      hold_left = 0;
      req_taken = 1'b0;

      // Directed: empty message, the classic three-byte message, and
      // single-byte messages at both extremes of the byte field.
      add_finish();
      add_byte(8'h61);
      add_byte(8'h62);
      add_byte(8'h63);
      add_finish();
      add_byte(8'hff);
      add_finish();
      add_byte(8'h00);
      add_finish();
      add_finish();

      // Random messages. Lengths cluster around the padding boundaries
      // (one or two final blocks, exact block multiples) with a few
      // multi-block messages. The last message is cut short so the total
      // stays near the planned item count.
      while (stim_q.size() < 470) begin
         pick = $urandom_range(99);
         if (pick < 60) len = $urandom_range(70);
         else if (pick < 88) len = 55 + $urandom_range(10);
         else len = 100 + $urandom_range(30);
         if (len > 470 - stim_q.size()) len = 470 - stim_q.size();
         add_message(len);
      end
      total_items = stim_q.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (stim_q.size() > 0 || req_ch.valid) @(negedge clock);
      while (digest_q.size() > 0) @(negedge clock);
      repeat (200) @(negedge clock);

      if (error_count == 0) begin
         $display("tb_sha256_message_digest_unit: clean");
      end else begin
         $display("tb_sha256_message_digest_unit: errors");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/shad_pkg.sv
rtl/shad_if.sv
rtl/shad_front.sv
rtl/shad_back.sv
rtl/sha256_message_digest_unit.sv
sim/tb_sha256_message_digest_unit.sv
